FILE: rtl/hlbp_pkg.sv
// ----------------------------------------------------------------------------
// hlbp_pkg
// Shared types, constants and helpers of the hidden layer backprop core.
// ----------------------------------------------------------------------------
package hlbp_pkg;

  localparam int NEURONS = 16;
  localparam int LINKS   = 16;
  localparam int ROWS    = NEURONS + 1;
  localparam int DEPTH   = ROWS * LINKS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = 5;
  localparam int LINK_W  = 4;
  localparam int VAL_W   = 24;
  localparam int OUT_W   = 17;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int ACC_W   = 2 * VAL_W + $clog2(LINKS) + 1;
  localparam int SAT_W   = 64;

  localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(65536);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_LR   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MOM  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BIAS = 2'd2;

  // input function codes
  localparam logic [2:0] FUNC_WW  = 3'd0;
  localparam logic [2:0] FUNC_WO  = 3'd1;
  localparam logic [2:0] FUNC_WD  = 3'd2;
  localparam logic [2:0] FUNC_RUN = 3'd3;
  localparam logic [2:0] FUNC_RD  = 3'd4;

  typedef enum logic [2:0] {
    OP_WW, OP_WO, OP_WD, OP_RUN, OP_RD
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ROW_W-1:0]        row;
    logic [LINK_W-1:0]       link;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_OUT, S_SUM_RD, S_SUM_MUL, S_SUM_ACC, S_SIG, S_DELTA,
    S_EMIT, S_LRO, S_UPD_RD, S_UPD_MUL, S_UPD_WR
  } state_t;

  // saturate to 24 bits signed
  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(8388607);
    lo = -SAT_W'(8388608);
    if (v > hi) return VAL_W'(hi);
    if (v < lo) return VAL_W'(lo);
    return VAL_W'(v);
  endfunction

  // flat address of one weight / change entry
  function automatic logic [ADDR_W-1:0] waddr(input logic [ROW_W-1:0] r,
                                              input logic [LINK_W-1:0] l);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(LINKS) + ADDR_W'(l));
  endfunction

endpackage

FILE: rtl/hlbp_front.sv
// ----------------------------------------------------------------------------
// hlbp_front
// Accepts input items, decodes the function and queues them for the back end.
// ----------------------------------------------------------------------------
module hlbp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       func,
  input  logic [hlbp_pkg::ROW_W-1:0]       neuron_index,
  input  logic [hlbp_pkg::LINK_W-1:0]      link_index,
  input  logic signed [hlbp_pkg::VAL_W-1:0] value,
  input  hlbp_pkg::back_ctl_t              ctl,
  output hlbp_pkg::head_t                  head
);

  hlbp_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  hlbp_pkg::item_t dec;
  logic            known;
  logic            push;
  logic            pop;

  // decode the function code, unknown codes are dropped
  always_comb begin
    dec.row   = neuron_index;
    dec.link  = link_index;
    dec.value = value;
    dec.op    = hlbp_pkg::OP_WW;
    known     = 1'b1;
    case (func)
      hlbp_pkg::FUNC_WW:  dec.op = hlbp_pkg::OP_WW;
      hlbp_pkg::FUNC_WO:  dec.op = hlbp_pkg::OP_WO;
      hlbp_pkg::FUNC_WD:  dec.op = hlbp_pkg::OP_WD;
      hlbp_pkg::FUNC_RUN: dec.op = hlbp_pkg::OP_RUN;
      hlbp_pkg::FUNC_RD:  dec.op = hlbp_pkg::OP_RD;
      default:            known  = 1'b0;
    endcase
  end

  assign in_stall   = (count == 2'd2) || ctl.clearing;
  assign push       = in_valid && !in_stall && known;
  assign pop        = ctl.pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  // two entry item queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
  end

endmodule

FILE: rtl/hlbp_back.sv
// ----------------------------------------------------------------------------
// hlbp_back
// Carries out queued items: loads, weight reads and the backprop run.
// ----------------------------------------------------------------------------
module hlbp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hlbp_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [hlbp_pkg::CFG_W-1:0]        cfg_data,
  input  hlbp_pkg::head_t                   head,
  output hlbp_pkg::back_ctl_t               ctl,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hlbp_pkg::VAL_W-1:0] result_value,
  output logic [hlbp_pkg::ROW_W-1:0]        result_index,
  output logic                              last
);

  localparam int AW = hlbp_pkg::ADDR_W;
  localparam int VW = hlbp_pkg::VAL_W;

  // configuration
  logic [hlbp_pkg::CFG_W-1:0] learning_rate;
  logic [hlbp_pkg::CFG_W-1:0] momentum;
  logic                       bias_enable;

  // stores
  logic signed [VW-1:0]               wmem [hlbp_pkg::DEPTH];
  logic signed [VW-1:0]               cmem [hlbp_pkg::DEPTH];
  logic [hlbp_pkg::OUT_W-1:0]         out_store [hlbp_pkg::NEURONS];
  logic signed [VW-1:0]               nd_store [hlbp_pkg::LINKS];
  logic signed [VW-1:0]               w_rdata;
  logic signed [VW-1:0]               c_rdata;

  // memory controls
  logic                 w_we, w_re, c_we, c_re;
  logic [AW-1:0]        w_waddr, raddr, c_waddr;
  logic signed [VW-1:0] w_wdata, c_wdata;

  // sequencer registers
  hlbp_pkg::state_t                state, state_next;
  logic [hlbp_pkg::ROW_W-1:0]      row;
  logic [hlbp_pkg::LINK_W-1:0]     j;
  logic [AW-1:0]                   clr_cnt;
  logic                            rd_ok;
  logic [hlbp_pkg::ROW_W-1:0]      rd_row;
  logic signed [hlbp_pkg::ACC_W-1:0] acc;
  logic signed [2*VW-1:0]          prod;
  logic signed [VW-1:0]            sum;
  logic [16:0]                     sig;
  logic signed [VW-1:0]            delta;
  logic [hlbp_pkg::OUT_W-1:0]      o_cur;
  logic [31:0]                     p1;
  logic signed [56:0]              pnd;
  logic signed [40:0]              mp;

  logic                 out_free;
  logic                 load_out;
  logic signed [VW-1:0] load_val;
  logic [hlbp_pkg::ROW_W-1:0] load_idx;
  logic                 load_last;
  logic signed [VW-1:0] dw;
  logic signed [57:0]   tsum;
  logic                 j_end;
  hlbp_pkg::item_t      it;

  assign it       = head.item;
  assign out_free = !out_valid || !out_stall;
  assign j_end    = (j == hlbp_pkg::LINK_W'(hlbp_pkg::LINKS - 1));
  assign tsum     = 58'(pnd) + (58'(mp) <<< 16);
  assign dw       = hlbp_pkg::sat24(hlbp_pkg::SAT_W'(tsum >>> 32));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 16'd6554;
      momentum      <= 16'd0;
      bias_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hlbp_pkg::CFG_LR:   learning_rate <= cfg_data;
        hlbp_pkg::CFG_MOM:  momentum      <= cfg_data;
        hlbp_pkg::CFG_BIAS: bias_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    ctl.pop      = 1'b0;
    ctl.clearing = (state == hlbp_pkg::S_CLEAR);
    w_we = 1'b0; w_re = 1'b0; c_we = 1'b0; c_re = 1'b0;
    w_waddr = hlbp_pkg::waddr(row, j);
    c_waddr = hlbp_pkg::waddr(row, j);
    raddr   = hlbp_pkg::waddr(row, j);
    w_wdata = it.value;
    c_wdata = dw;
    load_out  = 1'b0;
    load_val  = delta;
    load_idx  = row;
    load_last = (row == hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS - 1));
    case (state)
      hlbp_pkg::S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_cnt;
        c_wdata = '0;
        if (clr_cnt == AW'(hlbp_pkg::DEPTH - 1)) state_next = hlbp_pkg::S_IDLE;
      end
      hlbp_pkg::S_IDLE: begin
        if (head.valid) begin
          ctl.pop = 1'b1;
          raddr   = hlbp_pkg::waddr(it.row, it.link);
          w_waddr = hlbp_pkg::waddr(it.row, it.link);
          case (it.op)
            hlbp_pkg::OP_WW: begin
              w_we = (it.row <= hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS));
            end
            hlbp_pkg::OP_RUN: state_next = hlbp_pkg::S_SUM_RD;
            hlbp_pkg::OP_RD: begin
              w_re       = (it.row <= hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS));
              state_next = hlbp_pkg::S_RD_OUT;
            end
            default: ;
          endcase
        end
      end
      hlbp_pkg::S_RD_OUT: begin
        load_val  = rd_ok ? w_rdata : '0;
        load_idx  = rd_row;
        load_last = 1'b1;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = hlbp_pkg::S_IDLE;
        end
      end
      hlbp_pkg::S_SUM_RD: begin
        w_re       = 1'b1;
        state_next = hlbp_pkg::S_SUM_MUL;
      end
      hlbp_pkg::S_SUM_MUL: state_next = hlbp_pkg::S_SUM_ACC;
      hlbp_pkg::S_SUM_ACC: state_next = j_end ? hlbp_pkg::S_SIG : hlbp_pkg::S_SUM_RD;
      hlbp_pkg::S_SIG:     state_next = hlbp_pkg::S_DELTA;
      hlbp_pkg::S_DELTA:   state_next = hlbp_pkg::S_EMIT;
      hlbp_pkg::S_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = hlbp_pkg::S_LRO;
        end
      end
      hlbp_pkg::S_LRO: state_next = hlbp_pkg::S_UPD_RD;
      hlbp_pkg::S_UPD_RD: begin
        w_re       = 1'b1;
        c_re       = 1'b1;
        state_next = hlbp_pkg::S_UPD_MUL;
      end
      hlbp_pkg::S_UPD_MUL: state_next = hlbp_pkg::S_UPD_WR;
      hlbp_pkg::S_UPD_WR: begin
        w_we    = 1'b1;
        c_we    = 1'b1;
        w_wdata = hlbp_pkg::sat24(hlbp_pkg::SAT_W'(w_rdata) + hlbp_pkg::SAT_W'(dw));
        if (!j_end) begin
          state_next = hlbp_pkg::S_UPD_RD;
        end else if (row == hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS - 1)) begin
          state_next = bias_enable ? hlbp_pkg::S_LRO : hlbp_pkg::S_IDLE;
        end else if (row == hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS)) begin
          state_next = hlbp_pkg::S_IDLE;
        end else begin
          state_next = hlbp_pkg::S_SUM_RD;
        end
      end
      default: state_next = hlbp_pkg::S_IDLE;
    endcase
  end

  // state register and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hlbp_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == hlbp_pkg::S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // weight and change memories
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (w_re) w_rdata <= wmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (c_re) c_rdata <= cmem[raddr];
  end

  // output and delta stores
  always_ff @(posedge clk) begin
    if (state == hlbp_pkg::S_IDLE && head.valid) begin
      if (it.op == hlbp_pkg::OP_WO && it.row < hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS)) begin
        if (it.value < 0) out_store[it.row[hlbp_pkg::LINK_W-1:0]] <= '0;
        else if (it.value > VW'(65536))
          out_store[it.row[hlbp_pkg::LINK_W-1:0]] <= hlbp_pkg::ONE_Q16;
        else out_store[it.row[hlbp_pkg::LINK_W-1:0]] <= it.value[hlbp_pkg::OUT_W-1:0];
      end
      if (it.op == hlbp_pkg::OP_WD) nd_store[it.link] <= it.value;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      hlbp_pkg::S_IDLE: begin
        row    <= '0;
        j      <= '0;
        acc    <= '0;
        rd_row <= it.row;
        rd_ok  <= (it.row <= hlbp_pkg::ROW_W'(hlbp_pkg::NEURONS));
      end
      hlbp_pkg::S_SUM_MUL: prod <= nd_store[j] * w_rdata;
      hlbp_pkg::S_SUM_ACC: begin
        acc <= acc + hlbp_pkg::ACC_W'(prod);
        j   <= j + hlbp_pkg::LINK_W'(1);
      end
      hlbp_pkg::S_SIG: begin
        sum <= hlbp_pkg::sat24(hlbp_pkg::SAT_W'(acc >>> 16));
        sig <= 17'((34'(out_store[row[hlbp_pkg::LINK_W-1:0]]) *
                    34'(hlbp_pkg::ONE_Q16 - out_store[row[hlbp_pkg::LINK_W-1:0]])) >> 16);
      end
      hlbp_pkg::S_DELTA: begin
        delta <= hlbp_pkg::sat24(hlbp_pkg::SAT_W'(
                   (42'($signed({1'b0, sig})) * 42'(sum)) >>> 16));
      end
      hlbp_pkg::S_EMIT: o_cur <= out_store[row[hlbp_pkg::LINK_W-1:0]];
      hlbp_pkg::S_LRO: begin
        p1 <= 32'(learning_rate) * 32'(o_cur);
        j  <= '0;
      end
      hlbp_pkg::S_UPD_MUL: begin
        pnd <= $signed({1'b0, p1}) * nd_store[j];
        mp  <= $signed({1'b0, momentum}) * c_rdata;
      end
      hlbp_pkg::S_UPD_WR: begin
        j <= j + hlbp_pkg::LINK_W'(1);
        if (j_end) begin
          row   <= row + hlbp_pkg::ROW_W'(1);
          acc   <= '0;
          o_cur <= hlbp_pkg::ONE_Q16;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= load_val;
      result_index <= load_idx;
      last         <= load_last;
    end
  end

endmodule

FILE: rtl/hidden_layer_backprop_momentum_core.sv
// Loads leave the queue one at a time while idle; a weight read is registered in the
// weight memory, then in the result register. A run walks the 16 neuron rows: a
// read, multiply and accumulate step per link for the sum, then sigmoid, delta and
// emit, a learning rate step and a read, multiply and write step per link for the
// update; the bias row update follows if bias is enabled. Reset clears control
// state, then a clearing pass zeroes the change memory while no item is accepted.
// ----------------------------------------------------------------------------
// hidden_layer_backprop_momentum_core
// Sigmoid hidden layer with backpropagation and momentum, signed Q8.16.
// ----------------------------------------------------------------------------
module hidden_layer_backprop_momentum_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hlbp_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [hlbp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        func,
  input  logic [hlbp_pkg::ROW_W-1:0]        neuron_index,
  input  logic [hlbp_pkg::LINK_W-1:0]       link_index,
  input  logic signed [hlbp_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hlbp_pkg::VAL_W-1:0] result_value,
  output logic [hlbp_pkg::ROW_W-1:0]        result_index,
  output logic                              last
);

  hlbp_pkg::head_t     head;
  hlbp_pkg::back_ctl_t ctl;

  // front end with item queue
  hlbp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .neuron_index, .link_index,
    .value, .ctl, .head
  );

  // execution back end
  hlbp_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .head, .ctl,
    .out_valid, .out_stall, .result_value, .result_index, .last
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the hidden layer backprop core against a cycle-free predictor of the
// layer: loads, weight reads and run items are driven through the valid/stall
// handshake, every result item is compared field by field, and the test
// steps through several learning rate, momentum and bias settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT   = 20000;
  localparam int SETTLE       = 300;
  localparam int ITEMS_PHASE  = 43;

  typedef struct {
    logic signed [hlbp_pkg::VAL_W-1:0] val;
    logic [hlbp_pkg::ROW_W-1:0]        row;
    logic                              last;
  } result_t;

  // predictor of the layer plus the queue of results still owed
  class layer_model;
    longint  wts [hlbp_pkg::DEPTH];
    longint  chg [hlbp_pkg::DEPTH];
    longint  outs [hlbp_pkg::NEURONS];
    longint  nds [hlbp_pkg::LINKS];
    longint  lr;
    longint  mom;
    bit      bias_on;
    result_t owed [$];
    int      errors;

    function new();
      lr = 6554;
      mom = 0;
      bias_on = 1;
      errors = 0;
      foreach (chg[k]) chg[k] = 0;
    endfunction

    function longint clip24(longint x);
      if (x > 8388607) return 8388607;
      if (x < -8388608) return -8388608;
      return x;
    endfunction

    function void set_reg(logic [hlbp_pkg::CIDX_W-1:0] idx, logic [hlbp_pkg::CFG_W-1:0] d);
      case (idx)
        hlbp_pkg::CFG_LR:   lr = d;
        hlbp_pkg::CFG_MOM:  mom = d;
        hlbp_pkg::CFG_BIAS: bias_on = d[0];
        default: ;
      endcase
    endfunction

    // weight and momentum update of one row
    function void adjust_row(int r, longint o);
      longint t;
      longint dw;
      int k;
      for (int j = 0; j < hlbp_pkg::LINKS; j++) begin
        k = r * hlbp_pkg::LINKS + j;
        t = lr * (o * nds[j]) + (mom * chg[k]) * 65536;
        dw = clip24(t >>> 32);
        chg[k] = dw;
        wts[k] = clip24(wts[k] + dw);
      end
    endfunction

    function void push(longint v, int r, bit l);
      result_t e;
      e.val = hlbp_pkg::VAL_W'(v);
      e.row = hlbp_pkg::ROW_W'(r);
      e.last = l;
      owed.push_back(e);
    endfunction

    function void note_item(logic [2:0] f, logic [hlbp_pkg::ROW_W-1:0] r,
                            logic [hlbp_pkg::LINK_W-1:0] l,
                            logic signed [hlbp_pkg::VAL_W-1:0] v);
      longint acc;
      longint o;
      longint sg;
      case (f)
        hlbp_pkg::FUNC_WW: if (r <= hlbp_pkg::NEURONS) wts[r * hlbp_pkg::LINKS + l] = v;
        hlbp_pkg::FUNC_WO:
          if (r < hlbp_pkg::NEURONS) outs[r] = (v < 0) ? 0 : (v > 65536) ? 65536 : longint'(v);
        hlbp_pkg::FUNC_WD: nds[l] = v;
        hlbp_pkg::FUNC_RUN: begin
          for (int i = 0; i < hlbp_pkg::NEURONS; i++) begin
            acc = 0;
            o = outs[i];
            for (int j = 0; j < hlbp_pkg::LINKS; j++)
              acc += nds[j] * wts[i * hlbp_pkg::LINKS + j];
            acc = clip24(acc >>> 16);
            sg = (o * (65536 - o)) >>> 16;
            push(clip24((sg * acc) >>> 16), i, i == hlbp_pkg::NEURONS - 1);
            adjust_row(i, o);
          end
          if (bias_on) adjust_row(hlbp_pkg::NEURONS, 65536);
        end
        hlbp_pkg::FUNC_RD:
          push((r <= hlbp_pkg::NEURONS) ? wts[r * hlbp_pkg::LINKS + l] : 0, r, 1'b1);
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [hlbp_pkg::VAL_W-1:0] v,
                               logic [hlbp_pkg::ROW_W-1:0] r, logic l);
      result_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d row %0d last %0d", v, r, l);
        return;
      end
      e = owed.pop_front();
      if (e.val !== v || e.row !== r || e.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: exp value %0d row %0d last %0d, got %0d %0d %0d",
                   e.val, e.row, e.last, v, r, l);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [hlbp_pkg::CIDX_W-1:0]       cfg_index = '0;
  logic [hlbp_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [2:0]                        func = FUNC_SPARE7;
  logic [hlbp_pkg::ROW_W-1:0]        neuron_index = '0;
  logic [hlbp_pkg::LINK_W-1:0]       link_index = '0;
  logic signed [hlbp_pkg::VAL_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [hlbp_pkg::VAL_W-1:0] result_value;
  logic [hlbp_pkg::ROW_W-1:0]        result_index;
  logic                              last;

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         quiet_cycles = 0;
  layer_model layer;

  hidden_layer_backprop_momentum_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .neuron_index(neuron_index),
    .link_index(link_index), .value(value), .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_index(result_index), .last(last)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rx_idle_pct);
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) layer.check_result(result_value, result_index, last);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [2:0] f, logic [hlbp_pkg::ROW_W-1:0] r,
                           logic [hlbp_pkg::LINK_W-1:0] l,
                           logic signed [hlbp_pkg::VAL_W-1:0] v);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    func = f;
    neuron_index = r;
    link_index = l;
    value = v;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    layer.note_item(f, r, l, v);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [hlbp_pkg::CIDX_W-1:0] idx, logic [hlbp_pkg::CFG_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    layer.set_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait for every owed result, then let the bias row update finish
  task automatic drain();
    while (layer.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [hlbp_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      2: return hlbp_pkg::VAL_W'($urandom);
      default: return hlbp_pkg::VAL_W'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      send_item(hlbp_pkg::FUNC_WW, hlbp_pkg::ROW_W'($urandom_range(0, hlbp_pkg::NEURONS)),
                hlbp_pkg::LINK_W'($urandom), pick_value());
    else if (sel < 47)
      send_item(hlbp_pkg::FUNC_WO, hlbp_pkg::ROW_W'($urandom_range(0, hlbp_pkg::NEURONS - 1)),
                hlbp_pkg::LINK_W'($urandom),
                ($urandom_range(0, 3) == 0) ? pick_value() :
                                              hlbp_pkg::VAL_W'($urandom_range(0, 65536)));
    else if (sel < 57)
      send_item(hlbp_pkg::FUNC_WD, hlbp_pkg::ROW_W'($urandom), hlbp_pkg::LINK_W'($urandom),
                pick_value());
    else if (sel < 72)
      send_item(hlbp_pkg::FUNC_RD, hlbp_pkg::ROW_W'($urandom_range(0, hlbp_pkg::NEURONS)),
                hlbp_pkg::LINK_W'($urandom), hlbp_pkg::VAL_W'($urandom));
    else if (sel < 82)
      send_item(hlbp_pkg::FUNC_RUN, hlbp_pkg::ROW_W'($urandom), hlbp_pkg::LINK_W'($urandom),
                hlbp_pkg::VAL_W'($urandom));
    else
      send_item(3'($urandom_range(0, 7)), hlbp_pkg::ROW_W'($urandom),
                hlbp_pkg::LINK_W'($urandom), hlbp_pkg::VAL_W'($urandom));
  endtask

  initial begin
    layer = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first setting
    write_reg(hlbp_pkg::CFG_LR, 16'hffff);
    write_reg(hlbp_pkg::CFG_MOM, 16'd0);
    write_reg(hlbp_pkg::CFG_BIAS, 16'd1);
    tx_idle_pct = 11;
    rx_idle_pct = 73;

    // fill every store so nothing unwritten is ever read
    for (int r = 0; r <= hlbp_pkg::NEURONS; r++)
      for (int l = 0; l < hlbp_pkg::LINKS; l++)
        send_item(hlbp_pkg::FUNC_WW, hlbp_pkg::ROW_W'(r), hlbp_pkg::LINK_W'(l), pick_value());
    for (int r = 0; r < hlbp_pkg::NEURONS; r++)
      send_item(hlbp_pkg::FUNC_WO, hlbp_pkg::ROW_W'(r), 4'd0,
                hlbp_pkg::VAL_W'($urandom_range(0, 65536)));
    for (int l = 0; l < hlbp_pkg::LINKS; l++)
      send_item(hlbp_pkg::FUNC_WD, 5'd0, hlbp_pkg::LINK_W'(l), pick_value());

    // directed corners
    send_item(hlbp_pkg::FUNC_WW, 5'd0, 4'd0, 24'sh7fffff);
    send_item(hlbp_pkg::FUNC_RD, 5'd0, 4'd0, 24'sh0);
    send_item(hlbp_pkg::FUNC_WW, 5'd16, 4'd15, -24'sh800000);
    send_item(hlbp_pkg::FUNC_RD, 5'd16, 4'd15, 24'sh0);
    send_item(hlbp_pkg::FUNC_WW, 5'd17, 4'd0, 24'sh123456);
    send_item(hlbp_pkg::FUNC_WW, 5'd31, 4'd15, -24'sh1);
    send_item(hlbp_pkg::FUNC_RD, 5'd17, 4'd3, 24'sh0);
    send_item(hlbp_pkg::FUNC_RD, 5'd31, 4'd15, 24'sh0);
    send_item(hlbp_pkg::FUNC_WO, 5'd16, 4'd0, 24'sh8000);
    send_item(hlbp_pkg::FUNC_WO, 5'd31, 4'd0, 24'sh8000);
    send_item(hlbp_pkg::FUNC_WO, 5'd0, 4'd0, -24'sh800000);
    send_item(hlbp_pkg::FUNC_WO, 5'd1, 4'd0, 24'sh7fffff);
    send_item(hlbp_pkg::FUNC_WO, 5'd2, 4'd0, 24'sh10000);
    send_item(hlbp_pkg::FUNC_WO, 5'd3, 4'd0, 24'sh0);
    send_item(hlbp_pkg::FUNC_WD, 5'd31, 4'd15, 24'sh7fffff);
    send_item(hlbp_pkg::FUNC_WD, 5'd0, 4'd0, -24'sh800000);
    send_item(FUNC_SPARE5, 5'd31, 4'd15, -24'sh1);
    send_item(FUNC_SPARE6, 5'd0, 4'd0, 24'sh0);
    send_item(FUNC_SPARE7, 5'd16, 4'd8, 24'sh555555);
    send_item(hlbp_pkg::FUNC_RUN, 5'd0, 4'd0, 24'sh0);
    send_item(hlbp_pkg::FUNC_RD, 5'd1, 4'd1, 24'sh0);

    // random phases, each with its own setting
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(hlbp_pkg::CFG_LR, 16'd0);
          write_reg(hlbp_pkg::CFG_MOM, 16'hffff);
        end
        1: begin
          write_reg(hlbp_pkg::CFG_LR, 16'hffff);
          write_reg(hlbp_pkg::CFG_MOM, 16'hffff);
          write_reg(hlbp_pkg::CFG_BIAS, 16'd0);
          tx_idle_pct = 73;
          rx_idle_pct = 11;
        end
        2: begin
          write_reg(hlbp_pkg::CFG_LR, hlbp_pkg::CFG_W'($urandom));
          write_reg(hlbp_pkg::CFG_MOM, 16'h8000);
          write_reg(hlbp_pkg::CFG_BIAS, 16'd1);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        default: begin
          write_reg(hlbp_pkg::CFG_LR, 16'd6554);
          write_reg(hlbp_pkg::CFG_MOM, hlbp_pkg::CFG_W'($urandom));
        end
      endcase
      for (int n = 0; n < ITEMS_PHASE; n++) random_item();
      send_item(hlbp_pkg::FUNC_RUN, 5'd0, 4'd0, 24'sh0);
    end

    drain();
    if (layer.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hlbp_pkg.sv
rtl/hlbp_front.sv
rtl/hlbp_back.sv
rtl/hidden_layer_backprop_momentum_core.sv
verif/tb_top.sv
